/* design/cksa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the cipher key slot allocator.
// No dependencies; imported by every module of the block.
package cksa_pkg;

    // key table geometry: 128 entries held as 32 rows of 4 columns,
    // column k of row r is entry r + 32*k
    localparam int TABLE_ENTRIES = 128;
    localparam int MAP_ROWS      = 32;
    localparam int MAP_COLS      = 4;
    localparam int SLOT_W        = 7;
    localparam int ROW_W         = 5;
    localparam int CNT_W         = 8;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CNT_W-1:0] ENTRIES_CNT  = 8'd128;
    localparam logic [CNT_W-1:0] MIC_OFFSET   = 8'd64;
    localparam logic [CNT_W-1:0] SPLIT_OFFSET = 8'd32;
    localparam logic [CNT_W-1:0] HIGH_OFFSET  = 8'd96;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIC_COMBINED = 2'd1;

    // request function codes
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_INSTALL = 2'd1;
    localparam logic [1:0] FUNC_DELETE  = 2'd2;

    // cipher kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_CCMP  = 2'd1;
    localparam logic [1:0] KIND_TKIP  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // delete actions
    localparam logic [1:0] RK_NONE = 2'd0;
    localparam logic [1:0] RK_ADDR = 2'd1;
    localparam logic [1:0] RK_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        cipher_kind;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] result_slot;
        logic [1:0]        status;
        logic [1:0]        reset_kind;
        logic              partner_reset;
    } rsp_t;

    // search passes of auto allocation
    typedef enum logic [1:0] {
        SCAN_TKIP,
        SCAN_QUAD,
        SCAN_PAIR,
        SCAN_FREE
    } scan_t;

    // datapath commands
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_STEP,
        OP_RESTART,
        OP_HIT,
        OP_EXEC,
        OP_NOFREE,
        OP_PUSH
    } op_t;

    typedef struct packed {
        op_t   op;
        scan_t scan;
    } cmd_t;

    typedef struct packed {
        logic       in_range;
        logic       hit;
        logic [1:0] func;
        logic [1:0] kind;
        logic       mic_combined;
        logic       out_free;
    } stat_t;

endpackage

/* design/cksa_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the key slot allocator: configuration, slot maps, scan
// counter, install/delete logic and output register. Uses cksa_pkg.
module cksa_datapath #(
    parameter int GROUP_KEY_SLOTS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cksa_pkg::cmd_t                    cmd,
    output cksa_pkg::stat_t                   st,
    input  cksa_pkg::req_t                    in_item,
    output cksa_pkg::rsp_t                    out_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              cfg_we,
    input  logic [cksa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cksa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cksa_pkg::*;

    localparam logic [CNT_W-1:0] GROUP_CNT = CNT_W'(GROUP_KEY_SLOTS);

    // column mask of entry (column hi) plus 32*k, empty past the table
    function automatic logic [MAP_COLS-1:0] col_mask(input logic [1:0] hi,
                                                     input logic [1:0] k);
        logic [2:0] c;
        c = {1'b0, hi} + {1'b0, k};
        col_mask = c[2] ? '0 : (MAP_COLS'(1) << c[1:0]);
    endfunction

    // used bit of entry plus 32*k, past the table counts as used
    function automatic logic used_at(input logic [MAP_COLS-1:0] row,
                                     input logic [1:0] hi,
                                     input logic [1:0] k);
        logic [2:0] c;
        c = {1'b0, hi} + {1'b0, k};
        used_at = c[2] ? 1'b1 : row[c[1:0]];
    endfunction

    logic [CNT_W-1:0]    table_size_reg;
    logic                mic_combined_reg;
    logic [1:0]          func_reg;
    logic [1:0]          kind_reg;
    logic [SLOT_W-1:0]   ws_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [MAP_COLS-1:0] used_rows_reg [MAP_ROWS];
    logic [MAP_COLS-1:0] ccmp_rows_reg [MAP_ROWS];
    logic [MAP_COLS-1:0] tkip_rows_reg [MAP_ROWS];
    rsp_t                res_reg;
    rsp_t                out_reg;
    logic                out_valid_reg;

    logic [CNT_W-1:0]    eff_n;
    logic [ROW_W-1:0]    rd_row;
    logic [MAP_COLS-1:0] used_row;
    logic [MAP_COLS-1:0] ccmp_row;
    logic [MAP_COLS-1:0] tkip_row;
    logic                split;

    // effective table size and shared row read
    assign eff_n    = (table_size_reg > ENTRIES_CNT) ? ENTRIES_CNT : table_size_reg;
    assign split    = ~mic_combined_reg;
    assign rd_row   = (cmd.op == OP_EXEC) ? ws_reg[ROW_W-1:0] : idx_reg[ROW_W-1:0];
    assign used_row = used_rows_reg[rd_row];
    assign ccmp_row = ccmp_rows_reg[rd_row];
    assign tkip_row = tkip_rows_reg[rd_row];

    // scan evaluation of the entry under idx_reg
    logic [1:0]       idx_hi;
    logic [CNT_W-1:0] limit;
    logic             in_range;
    logic             hit;
    logic [CNT_W-1:0] hit_off;
    logic             u0, u1, u2, u3;
    logic             reserved;

    assign idx_hi = idx_reg[6:5];
    assign u0 = used_at(used_row, idx_hi, 2'd0);
    assign u1 = used_at(used_row, idx_hi, 2'd1);
    assign u2 = used_at(used_row, idx_hi, 2'd2);
    assign u3 = used_at(used_row, idx_hi, 2'd3);

    always_comb
    begin
        reserved = (idx_reg >= MIC_OFFSET) && (idx_reg < MIC_OFFSET + GROUP_CNT);
        if (split)
        begin
            reserved = reserved
                || ((idx_reg >= SPLIT_OFFSET) && (idx_reg < SPLIT_OFFSET + GROUP_CNT))
                || ((idx_reg >= HIGH_OFFSET) && (idx_reg < HIGH_OFFSET + GROUP_CNT));
        end
    end

    always_comb
    begin
        limit   = eff_n;
        hit     = 1'b0;
        hit_off = '0;
        case (cmd.scan)
            SCAN_TKIP:
            begin
                limit = eff_n >> 1;
                hit   = ~u0 & ~u2 & (mic_combined_reg | (~u1 & ~u3));
            end
            SCAN_QUAD:
            begin
                // partly used split group, first free member wins
                limit = eff_n >> 2;
                if (~u0 & (u1 | u2 | u3))
                begin
                    hit = 1'b1;
                end
                else if (~u1 & (u0 | u2 | u3))
                begin
                    hit     = 1'b1;
                    hit_off = SPLIT_OFFSET;
                end
                else if (~u2 & (u0 | u1 | u3))
                begin
                    hit     = 1'b1;
                    hit_off = MIC_OFFSET;
                end
                else if (~u3 & (u0 | u1 | u2))
                begin
                    hit     = 1'b1;
                    hit_off = HIGH_OFFSET;
                end
            end
            SCAN_PAIR:
            begin
                limit = eff_n >> 1;
                if (~u0 & u2)
                begin
                    hit = 1'b1;
                end
                else if (u0 & ~u2)
                begin
                    hit     = 1'b1;
                    hit_off = MIC_OFFSET;
                end
            end
            SCAN_FREE:
            begin
                hit = ~reserved & ~u0;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign in_range = idx_reg < limit;

    // install and delete on the work slot
    logic [1:0]          ws_hi;
    logic [CNT_W-1:0]    ws_cnt;
    logic                is_tkip;
    logic                inst_fail;
    logic [MAP_COLS-1:0] m0, m1, m2, m3;
    logic [MAP_COLS-1:0] set_used, set_ccmp, set_tkip;
    logic [MAP_COLS-1:0] clr_used, clr_ccmp, clr_tkip;
    logic                was_tkip, was_ccmp, del_ok;
    rsp_t                exec_rsp;
    rsp_t                nofree_rsp;

    assign ws_hi   = ws_reg[6:5];
    assign ws_cnt  = {1'b0, ws_reg};
    assign is_tkip = (kind_reg == KIND_TKIP);
    assign m0 = col_mask(ws_hi, 2'd0);
    assign m1 = col_mask(ws_hi, 2'd1);
    assign m2 = col_mask(ws_hi, 2'd2);
    assign m3 = col_mask(ws_hi, 2'd3);
    assign was_tkip = |(tkip_row & m0);
    assign was_ccmp = |(ccmp_row & m0);
    assign del_ok   = ws_cnt >= GROUP_CNT;

    always_comb
    begin
        inst_fail = (ws_cnt >= eff_n)
            || (is_tkip && (((ws_cnt + MIC_OFFSET) >= eff_n)
                || (split && ((ws_cnt + HIGH_OFFSET) >= eff_n))));
        set_used = m0;
        if (is_tkip)
        begin
            set_used = m0 | m2 | (split ? (m1 | m3) : '0);
        end
        set_ccmp = (kind_reg == KIND_CCMP) ? m0 : '0;
        set_tkip = is_tkip ? set_used : '0;
        clr_ccmp = del_ok ? m0 : '0;
        clr_tkip = (del_ok && was_tkip) ? (m0 | m2 | (split ? (m1 | m3) : '0)) : '0;
        clr_used = clr_ccmp | clr_tkip;

        exec_rsp = '0;
        case (func_reg)
            FUNC_ALLOC, FUNC_INSTALL:
            begin
                if (inst_fail)
                begin
                    exec_rsp.status = ST_RANGE;
                end
                else
                begin
                    exec_rsp.result_slot = ws_reg;
                end
            end
            FUNC_DELETE:
            begin
                exec_rsp.result_slot = ws_reg;
                if (ws_cnt >= eff_n)
                begin
                    exec_rsp.status     = ST_RANGE;
                    exec_rsp.reset_kind = RK_NONE;
                end
                else
                begin
                    exec_rsp.reset_kind = (was_ccmp | was_tkip) ? RK_ADDR : RK_FULL;
                end
                exec_rsp.partner_reset = split & was_tkip & del_ok
                    & ((ws_cnt + SPLIT_OFFSET) < eff_n);
            end
            default:
            begin
                exec_rsp.status = ST_RANGE;
            end
        endcase
    end

    // result of a search that found nothing
    always_comb
    begin
        nofree_rsp        = '0;
        nofree_rsp.status = ST_NO_FREE;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg   <= ENTRIES_CNT;
            mic_combined_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TABLE_SIZE:   table_size_reg   <= cfg_data;
                CFG_MIC_COMBINED: mic_combined_reg <= cfg_data[0];
                default:          table_size_reg   <= table_size_reg;
            endcase
        end
    end

    // request capture, scan counter and work slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg <= FUNC_ALLOC;
            kind_reg <= KIND_OTHER;
            ws_reg   <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    func_reg <= in_item.func;
                    kind_reg <= (in_item.cipher_kind == KIND_CCMP
                                 || in_item.cipher_kind == KIND_TKIP)
                                ? in_item.cipher_kind : KIND_OTHER;
                    ws_reg   <= in_item.slot_index;
                    idx_reg  <= GROUP_CNT;
                end
                OP_STEP:    idx_reg <= idx_reg + CNT_W'(1);
                OP_RESTART: idx_reg <= GROUP_CNT;
                OP_HIT:     ws_reg  <= SLOT_W'(idx_reg + hit_off);
                default:    idx_reg <= idx_reg;
            endcase
        end
    end

    // slot maps, one row read-modify-write per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAP_ROWS; r++)
            begin
                used_rows_reg[r] <= '0;
                ccmp_rows_reg[r] <= '0;
                tkip_rows_reg[r] <= '0;
            end
        end
        else if (cmd.op == OP_EXEC)
        begin
            if ((func_reg == FUNC_ALLOC || func_reg == FUNC_INSTALL) && !inst_fail)
            begin
                used_rows_reg[rd_row] <= used_row | set_used;
                ccmp_rows_reg[rd_row] <= ccmp_row | set_ccmp;
                tkip_rows_reg[rd_row] <= tkip_row | set_tkip;
            end
            else if (func_reg == FUNC_DELETE)
            begin
                used_rows_reg[rd_row] <= used_row & ~clr_used;
                ccmp_rows_reg[rd_row] <= ccmp_row & ~clr_ccmp;
                tkip_rows_reg[rd_row] <= tkip_row & ~clr_tkip;
            end
        end
    end

    // staged result
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EXEC)
        begin
            res_reg <= exec_rsp;
        end
        else if (cmd.op == OP_NOFREE)
        begin
            res_reg <= nofree_rsp;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_PUSH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUSH)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_item        = out_reg;
    assign out_valid       = out_valid_reg;
    assign st.in_range     = in_range;
    assign st.hit          = hit;
    assign st.func         = func_reg;
    assign st.kind         = kind_reg;
    assign st.mic_combined = mic_combined_reg;
    assign st.out_free     = ~out_valid_reg | out_ready;

    // a result is only pushed into a free output register
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUSH) |-> (!out_valid_reg || out_ready))
        else $error("result pushed over a pending transfer");

    // a TKIP entry is always marked used
    a_tkip_used: assert property (@(posedge clk) disable iff (!rst_n)
        (tkip_row & ~used_row) == '0)
        else $error("TKIP bit set on an unused entry");

    // a failed allocation carries no slot and no delete action
    a_nofree_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_NO_FREE)
        |-> (out_reg.result_slot == '0 && out_reg.reset_kind == RK_NONE
             && !out_reg.partner_reset))
        else $error("no-free result carries payload");

endmodule

/* design/cksa_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the key slot allocator: sequences load, search passes,
// map update and result transfer. Uses cksa_pkg.
module cksa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output cksa_pkg::cmd_t  cmd,
    input  cksa_pkg::stat_t st
);
    import cksa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_TKIP,
        S_QUAD,
        S_PAIR,
        S_FREE,
        S_EXEC,
        S_NOFREE,
        S_PUSH
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    assign in_ready = in_ready_reg;

    // command decode
    always_comb
    begin
        cmd.op   = OP_IDLE;
        cmd.scan = SCAN_FREE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.op = (in_valid && in_ready_reg) ? OP_LOAD : OP_IDLE;
            end
            S_TKIP:
            begin
                cmd.scan = SCAN_TKIP;
                cmd.op   = !st.in_range ? OP_IDLE : (st.hit ? OP_HIT : OP_STEP);
            end
            S_QUAD:
            begin
                cmd.scan = SCAN_QUAD;
                cmd.op   = !st.in_range ? OP_RESTART : (st.hit ? OP_HIT : OP_STEP);
            end
            S_PAIR:
            begin
                cmd.scan = SCAN_PAIR;
                cmd.op   = !st.in_range ? OP_RESTART : (st.hit ? OP_HIT : OP_STEP);
            end
            S_FREE:
            begin
                cmd.scan = SCAN_FREE;
                cmd.op   = !st.in_range ? OP_IDLE : (st.hit ? OP_HIT : OP_STEP);
            end
            S_EXEC:   cmd.op = OP_EXEC;
            S_NOFREE: cmd.op = OP_NOFREE;
            S_PUSH:   cmd.op = st.out_free ? OP_PUSH : OP_IDLE;
            default:  cmd.op = OP_IDLE;
        endcase
    end

    // state and ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready_reg)
                    begin
                        state_reg    <= S_START;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_START:
                begin
                    if (st.func == FUNC_ALLOC)
                    begin
                        if (st.kind == KIND_TKIP)
                        begin
                            state_reg <= S_TKIP;
                        end
                        else
                        begin
                            state_reg <= st.mic_combined ? S_PAIR : S_QUAD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_TKIP:
                begin
                    if (!st.in_range)
                    begin
                        state_reg <= S_NOFREE;
                    end
                    else if (st.hit)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_QUAD, S_PAIR:
                begin
                    if (!st.in_range)
                    begin
                        state_reg <= S_FREE;
                    end
                    else if (st.hit)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_FREE:
                begin
                    if (!st.in_range)
                    begin
                        state_reg <= S_NOFREE;
                    end
                    else if (st.hit)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC, S_NOFREE:
                begin
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    if (st.out_free)
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    // an accepted request always starts with dispatch
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_START))
        else $error("accepted request not dispatched");

endmodule

/* design/cipher_key_slot_allocator.sv */
`timescale 1ns / 1ps
// Top level of the cipher key slot allocator: controller plus datapath.
// Depends on cksa_pkg, cksa_ctrl and cksa_datapath.
//
// Usage:
//   in channel  (in_valid/in_ready/in_item): one request per transfer,
//     auto allocate, install at slot_index, or delete slot_index.
//   out channel (out_valid/out_ready/out_item): one result per request,
//     in request order.
//   cfg port (cfg_we/cfg_index/cfg_data): table_size at index 0,
//     mic_combined at index 1; write only while no request is in flight.
// Sequence: install and delete pass through the dispatch, execute and push
//   states after the request transfer. Auto allocation walks the table one
//   entry per cycle, each pass ending when the index reaches its limit:
//   TKIP scans n/2 - g entries (g = GROUP_KEY_SLOTS), other ciphers n/4 - g
//   (n/2 - g with combined MIC) group entries, then n - g free entries.
// One request at a time; the next is taken once the result is pushed
//   into the output register. Reset clears the slot maps and restores
//   table_size 128 and split MIC keys; a stalled receiver holds the result
//   and the following request waits to push its own.
module cipher_key_slot_allocator #(
    parameter int GROUP_KEY_SLOTS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  cksa_pkg::req_t                    in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cksa_pkg::rsp_t                    out_item,
    input  logic                              cfg_we,
    input  logic [cksa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cksa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cksa_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // sequencing
    cksa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .st       (st)
    );

    // maps, search and results
    cksa_datapath #(
        .GROUP_KEY_SLOTS (GROUP_KEY_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
